[src/cism_pkg.sv]
// Shared types, defaults and helper functions for the case-insensitive substring matcher.
package cism_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int MAX_MATCHES_DEF = 128;
    localparam int LINE_MAX_DEF    = 65536;

    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 5;
    localparam int LENGTH_W = 6;
    localparam int COLUMN_W = 16;
    localparam int COUNT_W  = 8;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic MODE_TEXT    = 1'b0;
    localparam logic MODE_PATTERN = 1'b1;

    typedef struct packed {
        logic                limit_reached;
        logic [COLUMN_W-1:0] match_start;
        logic                match_found;
    } result_t;

    // Folds ASCII upper case letters to lower case; all other bytes pass unchanged.
    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

[src/case_insensitive_substring_matcher_top.sv]
// Each result is registered in the output stage, via the skid register if m_axis stalls.
// One byte per cycle while ready; every pattern cell updates its prefix bit in parallel.
// A two-entry output stage keeps s_axis_tready high while one result waits downstream.
// Reset clears prefix bits, column, match count, length and handshake state;
// the pattern bytes stay undefined until written.
module case_insensitive_substring_matcher_top
    import cism_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int MAX_MATCHES = MAX_MATCHES_DEF,
    parameter int LINE_MAX    = LINE_MAX_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LENGTH_W-1:0]   cfg_data,       // pattern_length
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // data_byte[7:0], pattern_index[12:8], zeros
    input  logic                  s_axis_tuser,   // mode
    input  logic                  s_axis_tlast,   // line_end
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // match_found[0], match_start[16:1],
                                                  // limit_reached[17], zeros
);

    localparam logic [7:0]          PAT_MAX_8  = 8'(PATTERN_MAX);
    localparam logic [COUNT_W-1:0]  MATCH_CAP  = COUNT_W'(MAX_MATCHES);
    localparam logic [COLUMN_W-1:0] COL_LAST   = COLUMN_W'(LINE_MAX - 1);

    logic [LENGTH_W-1:0] pattern_length_reg;
    logic [COLUMN_W-1:0] column_reg;
    logic [COLUMN_W-1:0] column_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;

    logic [BYTE_W-1:0]      data_byte;
    logic [INDEX_W-1:0]     pattern_index;
    logic                   mode;
    logic                   line_end;
    logic                   accept;
    logic                   text_en;
    logic                   pat_en;
    logic [BYTE_W-1:0]      text_folded;
    logic [7:0]             len_eff;
    logic [PATTERN_MAX-1:0] cell_match;
    logic [PATTERN_MAX-1:0] cell_next;
    logic [PATTERN_MAX-1:0] cell_hit;
    logic                   hit;
    logic                   found;
    logic [COLUMN_W-1:0]    len_m1;
    result_t                result;
    result_t                out_result;

    assign data_byte     = s_axis_tdata[7:0];
    assign pattern_index = s_axis_tdata[12:8];
    assign mode          = s_axis_tuser;
    assign line_end      = s_axis_tlast;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign text_en = accept && (mode == MODE_TEXT);
    assign pat_en  = accept && (mode == MODE_PATTERN);

    assign text_folded = fold_case(data_byte);

    // Configuration is always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
        end
        else if (cfg_valid)
        begin
            pattern_length_reg <= cfg_data;
        end
    end

    assign len_eff = (8'(pattern_length_reg) > PAT_MAX_8) ? PAT_MAX_8 : 8'(pattern_length_reg);

    // Cell i holds the bit "text ending here matches pattern bytes 0..i".
    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_cell
        logic prev;
        if (i == 0)
        begin : g_head
            assign prev = 1'b1;
        end
        else
        begin : g_link
            assign prev = cell_match[i-1];
        end

        cism_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .wr_en      (pat_en && (8'(pattern_index) == 8'(i))),
            .wr_byte    (data_byte),
            .text_en    (text_en),
            .line_clr   (line_end),
            .text_folded(text_folded),
            .prev_match (prev),
            .match      (cell_match[i]),
            .match_next (cell_next[i])
        );

        assign cell_hit[i] = cell_next[i] && (len_eff == 8'(i + 1));
    end

    assign hit    = |cell_hit;
    assign found  = hit && (count_reg < MATCH_CAP);
    assign len_m1 = COLUMN_W'(len_eff) - COLUMN_W'(1);

    always_comb
    begin
        result = '0;
        count_next = count_reg + COUNT_W'(found);
        if (mode == MODE_TEXT)
        begin
            result.match_found   = found;
            result.match_start   = found ? ((column_reg >= len_m1) ? column_reg - len_m1 : '0)
                                         : '0;
            result.limit_reached = (count_next >= MATCH_CAP);
        end
        column_next = (column_reg < COL_LAST) ? column_reg + COLUMN_W'(1) : column_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            count_reg  <= '0;
        end
        else if (text_en)
        begin
            if (line_end)
            begin
                column_reg <= '0;
                count_reg  <= '0;
            end
            else
            begin
                column_reg <= column_next;
                count_reg  <= count_next;
            end
        end
    end

    cism_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (result),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (out_result)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_result};

endmodule

[src/cism_cell.sv]
// One pattern position: its folded pattern byte and its prefix-match bit.
module cism_cell
    import cism_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [BYTE_W-1:0] wr_byte,
    input  logic              text_en,
    input  logic              line_clr,
    input  logic [BYTE_W-1:0] text_folded,
    input  logic              prev_match,
    output logic              match,
    output logic              match_next
);

    logic [BYTE_W-1:0] pattern_reg;
    logic              match_reg;

    // The pattern byte is kept folded, so a text byte compares with one equality.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pattern_reg <= fold_case(wr_byte);
        end
    end

    assign match_next = prev_match && (pattern_reg == text_folded);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (text_en)
        begin
            match_reg <= line_clr ? 1'b0 : match_next;
        end
    end

    assign match = match_reg;

endmodule

[src/cism_out_buf.sv]
// Output register with a skid stage so the input side never waits on a combinational ready.
module cism_out_buf
    import cism_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    take;
    logic    room;

    assign in_ready = !skid_valid_reg;
    assign take     = in_valid && !skid_valid_reg;
    assign room     = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (room)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (take)
        begin
            if (room)
            begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[test/tb.sv]
// Testbench for the case-insensitive substring matcher: a directed table, then random lines.
module tb
    import cism_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1000;
    localparam int N_ROWS       = 22;

    typedef struct packed {
        logic                mode;
        logic [BYTE_W-1:0]   data;
        logic [INDEX_W-1:0]  idx;
        logic                last;
    } text_item_t;

    typedef enum logic {ROW_ITEM, ROW_LENGTH} row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic                mode;
        logic [BYTE_W-1:0]   data;
        logic [INDEX_W-1:0]  idx;
        logic                last;
        logic [LENGTH_W-1:0] len;
        logic                typed;
        result_t             want;
    } row_t;

    localparam result_t NO_HIT   = '0;
    localparam result_t HIT_AT_0 = '{limit_reached: 1'b0, match_start: 16'd0, match_found: 1'b1};

    // Rows with typed set carry their own expected result; the rest use the predictor.
    localparam row_t DIRECTED [N_ROWS] = '{
        '{ROW_ITEM,   MODE_TEXT,    8'h61, 5'd0,  1'b1, 6'd0, 1'b1, NO_HIT},
        '{ROW_ITEM,   MODE_PATTERN, 8'h00, 5'd0,  1'b0, 6'd0, 1'b1, NO_HIT},
        '{ROW_ITEM,   MODE_PATTERN, 8'hFF, 5'd31, 1'b1, 6'd0, 1'b1, NO_HIT},
        '{ROW_LENGTH, MODE_TEXT,    8'h00, 5'd0,  1'b0, 6'd1, 1'b0, NO_HIT},
        '{ROW_ITEM,   MODE_TEXT,    8'h00, 5'd0,  1'b0, 6'd0, 1'b1, HIT_AT_0},
        '{ROW_ITEM,   MODE_TEXT,    8'hFF, 5'd0,  1'b1, 6'd0, 1'b1, NO_HIT},
        '{ROW_ITEM,   MODE_PATTERN, 8'h51, 5'd0,  1'b0, 6'd0, 1'b1, NO_HIT},
        '{ROW_ITEM,   MODE_PATTERN, 8'h5B, 5'd1,  1'b0, 6'd0, 1'b1, NO_HIT},
        '{ROW_ITEM,   MODE_PATTERN, 8'h71, 5'd2,  1'b0, 6'd0, 1'b1, NO_HIT},
        '{ROW_LENGTH, MODE_TEXT,    8'h00, 5'd0,  1'b0, 6'd3, 1'b0, NO_HIT},
        '{ROW_ITEM,   MODE_TEXT,    8'h71, 5'd0,  1'b0, 6'd0, 1'b0, NO_HIT},
        '{ROW_ITEM,   MODE_TEXT,    8'h5B, 5'd0,  1'b0, 6'd0, 1'b0, NO_HIT},
        '{ROW_ITEM,   MODE_TEXT,    8'h51, 5'd0,  1'b0, 6'd0, 1'b0, NO_HIT},
        '{ROW_ITEM,   MODE_TEXT,    8'h5B, 5'd0,  1'b0, 6'd0, 1'b0, NO_HIT},
        '{ROW_ITEM,   MODE_TEXT,    8'h71, 5'd0,  1'b1, 6'd0, 1'b0, NO_HIT},
        '{ROW_ITEM,   MODE_TEXT,    8'h51, 5'd0,  1'b0, 6'd0, 1'b0, NO_HIT},
        '{ROW_ITEM,   MODE_TEXT,    8'h7B, 5'd0,  1'b0, 6'd0, 1'b0, NO_HIT},
        '{ROW_ITEM,   MODE_TEXT,    8'h71, 5'd0,  1'b1, 6'd0, 1'b0, NO_HIT},
        '{ROW_ITEM,   MODE_PATTERN, 8'h40, 5'd0,  1'b0, 6'd0, 1'b1, NO_HIT},
        '{ROW_LENGTH, MODE_TEXT,    8'h00, 5'd0,  1'b0, 6'd1, 1'b0, NO_HIT},
        '{ROW_ITEM,   MODE_TEXT,    8'h60, 5'd0,  1'b0, 6'd0, 1'b0, NO_HIT},
        '{ROW_ITEM,   MODE_TEXT,    8'h40, 5'd0,  1'b1, 6'd0, 1'b0, NO_HIT}
    };

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [LENGTH_W-1:0]   cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // data_byte[7:0], pattern_index[12:8], zeros
    logic                  s_axis_tuser  = 1'b0; // mode
    logic                  s_axis_tlast  = 1'b0; // line_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // match_found[0], match_start[16:1],
                                                 // limit_reached[17], zeros

    // Predictor state.
    logic [BYTE_W-1:0]          pattern_mem [PATTERN_MAX_DEF] = '{default: '0};
    logic [PATTERN_MAX_DEF-1:0] prefix_hits  = '0;
    int unsigned                line_column  = 0;
    int unsigned                line_matches = 0;
    logic [LENGTH_W-1:0]        length_reg   = '0;

    result_t     expected_results [$];
    text_item_t  phase_q [$];
    int unsigned mismatches = 0;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    bit          pace_on    = 1'b1;

    case_insensitive_substring_matcher_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [BYTE_W-1:0] lower_ascii(input logic [BYTE_W-1:0] b);
        return (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
    endfunction

    // Advances the matcher by one transaction and returns the result it must produce.
    function automatic result_t advance_matcher(input text_item_t it);
        result_t           r;
        logic [BYTE_W-1:0] lb;
        int unsigned       span;
        r = '0;
        if (it.mode == MODE_PATTERN)
        begin
            pattern_mem[it.idx] = it.data;
            return r;
        end
        span = (length_reg > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : length_reg;
        lb = lower_ascii(it.data);
        for (int k = PATTERN_MAX_DEF - 1; k > 0; k--)
        begin
            prefix_hits[k] = prefix_hits[k-1] && (lower_ascii(pattern_mem[k]) == lb);
        end
        prefix_hits[0] = (lower_ascii(pattern_mem[0]) == lb);
        if (span != 0 && prefix_hits[span-1] && line_matches < MAX_MATCHES_DEF)
        begin
            r.match_found = 1'b1;
            r.match_start = (line_column >= span - 1) ? 16'(line_column - (span - 1)) : '0;
            line_matches++;
        end
        r.limit_reached = (line_matches >= MAX_MATCHES_DEF);
        if (line_column < LINE_MAX_DEF - 1)
        begin
            line_column++;
        end
        if (it.last)
        begin
            prefix_hits  = '0;
            line_column  = 0;
            line_matches = 0;
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!pace_on)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            return 0;
        end
        return (roll < 93) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    endfunction

    function automatic logic [BYTE_W-1:0] vary_case(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] lc;
        lc = lower_ascii(c);
        if (lc >= "a" && lc <= "z" && $urandom_range(0, 1) == 1)
        begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_letter(input int unsigned letters);
        return vary_case(8'(8'h61 + $urandom_range(0, letters - 1)));
    endfunction

    function automatic logic [BYTE_W-1:0] filler_byte(input int unsigned letters);
        return ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : pick_letter(letters);
    endfunction

    function automatic void add_text(input logic [BYTE_W-1:0] data, input logic last);
        phase_q.push_back('{MODE_TEXT, data, INDEX_W'(0), last});
    endfunction

    // line_end is random on pattern writes since the block ignores it there.
    function automatic void add_write(input int unsigned idx, input logic [BYTE_W-1:0] data);
        phase_q.push_back('{MODE_PATTERN, data, INDEX_W'(idx), 1'($urandom_range(0, 1))});
    endfunction

    function automatic void note_mismatch(input string what, input result_t want,
                                          input result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t %s: expected found=%0d start=%0d limit=%0d, got found=%0d start=%0d limit=%0d",
                     $realtime, what, want.match_found, want.match_start, want.limit_reached,
                     got.match_found, got.match_start, got.limit_reached);
        end
    endfunction

    // Keeps tvalid high into the next transaction when no gap follows.
    task automatic send_item(input text_item_t it, input bit more, input bit typed,
                             input result_t want);
        result_t predicted;
        if (gap_left != 0)
        begin
            repeat (gap_left) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.mode;
        s_axis_tlast  <= it.last;
        s_axis_tdata  <= {3'b000, it.idx, it.data};
        do @(posedge clk); while (!s_axis_tready);
        predicted = advance_matcher(it);
        expected_results.push_back(typed ? want : predicted);
        gap_left = pick_gap();
        if (!more || gap_left != 0)
        begin
            s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic set_length(input logic [LENGTH_W-1:0] value);
        while (expected_results.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        length_reg = value;
    endtask

    task automatic run_queue();
        for (int n = 0; n < phase_q.size(); n++)
        begin
            send_item(phase_q[n], n + 1 < phase_q.size(), 1'b0, NO_HIT);
        end
        phase_q.delete();
    endtask

    // Writes the pattern, then builds lines of copies of it, whole or cut, and filler bytes.
    task automatic build_random_phase(input logic [LENGTH_W-1:0] length, input bit fill_all);
        logic [BYTE_W-1:0] pat [PATTERN_MAX_DEF];
        int unsigned       span, letters, target, count, cut, roll, k;
        span = (length > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : length;
        letters = ($urandom_range(0, 1) == 1) ? 2 : 6;
        for (int j = 0; j < PATTERN_MAX_DEF; j++)
        begin
            pat[j] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : pick_letter(letters);
        end
        for (int j = 0; j < (fill_all ? PATTERN_MAX_DEF : span); j++)
        begin
            add_write(j, pat[j]);
        end
        repeat ($urandom_range(1, 4))
        begin
            target = $urandom_range(1, 2 * span + 24);
            count = 0;
            while (count < target)
            begin
                roll = $urandom_range(0, 99);
                if (span != 0 && roll < 40)
                begin
                    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, span) : span;
                    for (int j = 0; j < cut; j++)
                    begin
                        add_text(vary_case(pat[j]), 1'b0);
                    end
                    count += cut;
                end
                else if (roll < 45)
                begin
                    // A pattern change in mid-line acts only on bytes that follow it.
                    k = $urandom_range(0, PATTERN_MAX_DEF - 1);
                    pat[k] = ($urandom_range(0, 1) == 1) ? pick_letter(letters)
                                                         : 8'($urandom_range(0, 255));
                    add_write(k, pat[k]);
                end
                else
                begin
                    add_text(filler_byte(letters), 1'b0);
                    count++;
                end
            end
            add_text(filler_byte(letters), 1'b1);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (pace_on && $urandom_range(0, 99) < 15)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[17:0];
            if (expected_results.size() == 0)
            begin
                note_mismatch("result with nothing pending", NO_HIT, got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.match_found !== want.match_found
                    || got.match_start !== want.match_start
                    || got.limit_reached !== want.limit_reached)
                begin
                    note_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    initial
    begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int unsigned         drawn;
        int unsigned         phase;
        logic [LENGTH_W-1:0] length;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_LENGTH)
            begin
                set_length(DIRECTED[r].len);
            end
            else
            begin
                send_item('{DIRECTED[r].mode, DIRECTED[r].data, DIRECTED[r].idx,
                            DIRECTED[r].last},
                          r + 1 < N_ROWS && DIRECTED[r+1].kind == ROW_ITEM,
                          DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        // Overlapping matches past the per-line limit, then a fresh line.
        set_length(6'd2);
        add_write(0, "a");
        add_write(1, "A");
        repeat (140) add_text(vary_case("a"), 1'b0);
        add_text("a", 1'b1);
        repeat (3) add_text(vary_case("a"), 1'b0);
        add_text("A", 1'b1);
        run_queue();

        drawn = 0;
        phase = 0;
        while (drawn < RANDOM_ITEMS)
        begin
            case (phase)
                0: length = 6'(PATTERN_MAX_DEF);
                1: length = 6'h3F;
                2: length = 6'd0;
                3: length = 6'd1;
                default:
                begin
                    case ($urandom_range(0, 9))
                        0: length = 6'd0;
                        1: length = 6'd1;
                        2: length = 6'(PATTERN_MAX_DEF);
                        3: length = 6'h3F;
                        default: length = 6'($urandom_range(2, 6));
                    endcase
                end
            endcase
            pace_on = ($urandom_range(0, 3) != 0);
            set_length(length);
            // The first phase writes every entry, so no unwritten entry is ever read.
            build_random_phase(length, phase == 0);
            drawn += phase_q.size();
            run_queue();
            phase++;
        end

        while (expected_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
